### src/assert_macros.svh
// Assertion macros shared by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SADM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SADM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/sadm_pkg.sv
// Types, sizes and helpers for the SAD template matcher.
package sadm_pkg;

    localparam int NumTemplates = 16;
    localparam int RegionHeight = 26;
    localparam int RegionWidth  = 46;
    localparam int RegionPixels = RegionHeight * RegionWidth;

    localparam int AddrW  = (RegionPixels > 1) ? $clog2(RegionPixels) : 1;
    localparam int IdxW   = (NumTemplates > 1) ? $clog2(NumTemplates) : 1;
    localparam int TidxW  = 4;
    localparam int PixW   = 11;
    localparam int ColW   = 8;
    localparam int DiffW  = 10;
    localparam int SumW   = 20;
    localparam int CmpW   = (IdxW > TidxW) ? IdxW : TidxW;

    localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_MATCH = 1'b1
    } t_func;

    typedef logic [3*ColW-1:0] t_rgb;

    // Input beat payload.
    typedef struct packed {
        logic              func;
        logic [TidxW-1:0]  template_index;
        logic [PixW-1:0]   pixel_index;
        logic [ColW-1:0]   blue;
        logic [ColW-1:0]   green;
        logic [ColW-1:0]   red;
        logic              last;
    } t_pix;

    // Result beat payload.
    typedef struct packed {
        logic [TidxW-1:0]  best_index;
        logic [SumW-1:0]   best_sum;
    } t_res;

    // Beat as it travels down the cell chain, with the running best.
    typedef struct packed {
        logic              vld;
        logic              func;
        logic [TidxW-1:0]  tidx;
        logic [PixW-1:0]   pidx;
        logic              hit;
        logic [ColW-1:0]   blue;
        logic [ColW-1:0]   green;
        logic [ColW-1:0]   red;
        logic              last;
        logic              best_vld;
        logic [IdxW-1:0]   best_idx;
        logic [SumW-1:0]   best_sum;
    } t_beat;

    function automatic logic [ColW-1:0] abs_diff8(input logic [ColW-1:0] a,
                                                  input logic [ColW-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### src/sadm_pix_if.sv
// Pixel input channel: valid/ready with a pixel payload.
interface sadm_pix_if;
    logic           valid;
    logic           ready;
    sadm_pkg::t_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/sadm_res_if.sv
// Result output channel: valid/ready with best index and sum.
interface sadm_res_if;
    logic           valid;
    logic           ready;
    sadm_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/sad_template_argmin_match.sv
// Top level: SAD template matcher built as a chain of per-template cells.
//
// Usage:
//  - i_pix carries pixel beats. func = load writes the pixel into template
//    template_index at pixel_index; func = match streams a frame pixel of the
//    26 x 46 region. Loads outside the bank or region are dropped.
//  - o_res carries one beat per frame pixel marked last: the template with
//    the smallest sum of absolute differences (lowest index on ties) and
//    that sum. All accumulators are cleared behind that pixel.
//  - Throughput: one beat per cycle while o_res is not stalled. Each beat walks
//    the chain of 16 cells, four register stages per cell (memory read,
//    difference, accumulate, argmin step), plus the output register. The
//    first stage loads on the accepting edge, and o_res.valid for a last pixel
//    rises once the beat has left the last cell and the output register.
//  - Stall: o_res has an output register; while it holds an untaken result
//    the whole chain freezes and i_pix.ready drops. Otherwise ready is high.
//  - Reset: clears all stage valids, the accumulators and the output valid.
//    Template memories are not cleared; matching against a never-loaded
//    pixel gives an unspecified sum.
`include "assert_macros.svh"

module sad_template_argmin_match (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sadm_pix_if.sink   i_pix,
    sadm_res_if.source o_res
);
    import sadm_pkg::*;

    t_beat w_head;
    t_beat w_link [NumTemplates];
    t_beat w_tail;
    logic  w_adv;
    logic  w_tail_res;
    logic  r_out_vld;
    t_res  r_res;

    // Chain advances unless a result is waiting and not taken.
    assign w_adv       = !r_out_vld || o_res.ready;
    assign i_pix.ready = w_adv;

    // Head of chain: input beat, region check done once here.
    always_comb begin
        w_head          = '0;
        w_head.vld      = i_pix.valid;
        w_head.func     = i_pix.data.func;
        w_head.tidx     = i_pix.data.template_index;
        w_head.pidx     = i_pix.data.pixel_index;
        w_head.hit      = (32'(i_pix.data.pixel_index) < RegionPixels);
        w_head.blue     = i_pix.data.blue;
        w_head.green    = i_pix.data.green;
        w_head.red      = i_pix.data.red;
        w_head.last     = i_pix.data.last;
        w_head.best_vld = 1'b0;
    end

    for (genvar k = 0; k < NumTemplates; k++) begin : g_cell
        if (k == 0) begin : g_first
            sadm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_idx   (IdxW'(k)),
                .i_beat  (w_head),
                .o_beat  (w_link[k])
            );
        end else begin : g_next
            sadm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_idx   (IdxW'(k)),
                .i_beat  (w_link[k-1]),
                .o_beat  (w_link[k])
            );
        end
    end

    assign w_tail     = w_link[NumTemplates-1];
    assign w_tail_res = w_tail.vld && (w_tail.func == FUNC_MATCH) && w_tail.last;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_tail_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_tail_res) begin
            r_res.best_index <= TidxW'(w_tail.best_idx);
            r_res.best_sum   <= w_tail.best_sum;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_res;

    `SADM_ASSERT(a_res_issued, i_clk, i_rst_n, w_adv && w_tail_res |=> r_out_vld, "last pixel gave no result")
    `SADM_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !r_out_vld, "output valid survived reset")

endmodule

### src/sadm_cell.sv
// One template cell: template memory, SAD accumulator and argmin step.
`include "assert_macros.svh"

module sadm_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic [sadm_pkg::IdxW-1:0] i_idx,
    input  sadm_pkg::t_beat       i_beat,
    output sadm_pkg::t_beat       o_beat
);
    import sadm_pkg::*;

    t_rgb             r_mem [RegionPixels];
    t_rgb             r_rd;
    t_beat            r_a;
    t_beat            r_b;
    t_beat            r_c;
    t_beat            r_o;
    t_beat            n_o;
    logic [DiffW-1:0] r_d;
    logic [DiffW-1:0] n_d;
    logic [SumW-1:0]  r_acc;
    logic [SumW-1:0]  r_fin;
    logic [SumW:0]    w_sum;
    logic [SumW-1:0]  w_sat;
    logic [AddrW-1:0] w_addr;
    logic             w_sel;
    logic             w_take;

    assign w_addr = AddrW'(i_beat.pidx);
    assign w_sel  = (CmpW'(i_beat.tidx) == CmpW'(i_idx));

    // Template memory: one write port for loads, one registered read for matching.
    always_ff @(posedge i_clk) begin
        if (i_adv && i_beat.vld && (i_beat.func == FUNC_LOAD) && w_sel && i_beat.hit) begin
            r_mem[w_addr] <= {i_beat.red, i_beat.green, i_beat.blue};
        end
        if (i_adv) begin
            r_rd <= r_mem[w_addr];
        end
    end

    // Per-pixel difference, zero unless an in-region frame pixel.
    always_comb begin
        n_d = DiffW'(abs_diff8(r_a.blue,  r_rd[ColW-1:0]))
            + DiffW'(abs_diff8(r_a.green, r_rd[2*ColW-1:ColW]))
            + DiffW'(abs_diff8(r_a.red,   r_rd[3*ColW-1:2*ColW]));
        if (!((r_a.func == FUNC_MATCH) && r_a.hit)) begin
            n_d = '0;
        end
    end

    // Saturating accumulate.
    assign w_sum = {1'b0, r_acc} + (SumW+1)'(r_d);
    assign w_sat = w_sum[SumW] ? SumMax : w_sum[SumW-1:0];

    // Argmin step: strict less-than keeps the earlier (lower) index on ties.
    assign w_take = !r_c.best_vld || (r_fin < r_c.best_sum);

    always_comb begin
        n_o = r_c;
        if ((r_c.func == FUNC_MATCH) && r_c.last && w_take) begin
            n_o.best_vld = 1'b1;
            n_o.best_idx = i_idx;
            n_o.best_sum = r_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a   <= '0;
            r_b   <= '0;
            r_c   <= '0;
            r_o   <= '0;
            r_acc <= '0;
        end else if (i_adv) begin
            r_a <= i_beat;
            r_b <= r_a;
            r_c <= r_b;
            r_o <= n_o;
            if (r_b.vld && (r_b.func == FUNC_MATCH)) begin
                if (r_b.last) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= w_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d <= n_d;
            if (r_b.vld && (r_b.func == FUNC_MATCH) && r_b.last) begin
                r_fin <= w_sat;
            end
        end
    end

    assign o_beat = r_o;

    `SADM_ASSERT(a_acc_clear, i_clk, i_rst_n, i_adv && r_b.vld && r_b.func && r_b.last |=> r_acc == '0, "accumulator not cleared after last pixel")
    `SADM_ASSERT(a_acc_hold, i_clk, i_rst_n, !i_adv |=> $stable(r_acc), "accumulator moved during stall")

endmodule
